### hdl/srie_pkg.sv
// Shared constants, codes and types of the small RISC instruction executor.
package srie_pkg;

   // Memory size must be a power of two; addresses wrap by dropping high bits.
   localparam int MEM_WORDS = 1024;
   localparam int PC_W      = $clog2(MEM_WORDS);
   localparam int NUM_REGS  = 32;
   localparam int REG_W     = $clog2(NUM_REGS);
   localparam int XLEN      = 32;

   localparam int ACTION_W  = 2;
   localparam int ADDR_W    = 10;
   localparam int OUT_PC_W  = 10;

   // Result queue entries; the queue pointers are one bit wide.
   localparam int Q_DEPTH   = 2;

   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_WRITE   = 2'd0;
   localparam action_type ACT_STEP    = 2'd1;
   localparam action_type ACT_RESTART = 2'd2;

   typedef logic [5:0] opcode_type;

   localparam opcode_type OP_ADD  = 6'd0;
   localparam opcode_type OP_ADDI = 6'd1;
   localparam opcode_type OP_SUB  = 6'd2;
   localparam opcode_type OP_SUBI = 6'd3;
   localparam opcode_type OP_SGE  = 6'd4;
   localparam opcode_type OP_SGT  = 6'd5;
   localparam opcode_type OP_SEQ  = 6'd6;
   localparam opcode_type OP_BT   = 6'd7;
   localparam opcode_type OP_BF   = 6'd8;
   localparam opcode_type OP_BA   = 6'd9;
   localparam opcode_type OP_ST   = 6'd10;
   localparam opcode_type OP_LD   = 6'd11;
   localparam opcode_type OP_CALL = 6'd12;
   localparam opcode_type OP_JMP  = 6'd13;
   localparam opcode_type OP_MUL  = 6'd14;
   localparam opcode_type OP_SEQI = 6'd15;
   localparam opcode_type OP_HALT = 6'd16;

   localparam logic [REG_W-1:0] REG_ZERO = 5'd0;
   localparam logic [REG_W-1:0] REG_LINK = 5'd31;

   // Outcome of one executed instruction.
   typedef struct packed {
      logic [PC_W-1:0]  npc;
      logic             wb;
      logic [REG_W-1:0] widx;
      logic [XLEN-1:0]  wval;
      logic             halt;
      logic             bad;
      logic             is_ld;
      logic             is_st;
      logic [PC_W-1:0]  maddr;
   } exec_type;

   // One result word as it waits in the output queue.
   typedef struct packed {
      logic [OUT_PC_W-1:0] next_pc;
      logic                halted;
      logic                illegal;
      logic                reg_written;
      logic [REG_W-1:0]    reg_index;
      logic [XLEN-1:0]     reg_value;
   } result_type;

endpackage

### hdl/srie_req_if.sv
// Request channel: valid/ready handshake with action, address and data word.
interface srie_req_if;
   logic                            valid;
   logic                            ready;
   logic [srie_pkg::ACTION_W-1:0]   action;
   logic [srie_pkg::ADDR_W-1:0]     address;
   logic [srie_pkg::XLEN-1:0]       word_data;

   modport source (output valid, action, address, word_data, input ready);
   modport sink   (input valid, action, address, word_data, output ready);
endinterface

### hdl/srie_rsp_if.sv
// Response channel: valid/ready handshake with the core state after each item.
interface srie_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [srie_pkg::OUT_PC_W-1:0]   next_pc;
   logic                            halted;
   logic                            illegal;
   logic                            reg_written;
   logic [srie_pkg::REG_W-1:0]      reg_index;
   logic [srie_pkg::XLEN-1:0]       reg_value;

   modport source (output valid, next_pc, halted, illegal, reg_written, reg_index,
                   reg_value, input ready);
   modport sink   (input valid, next_pc, halted, illegal, reg_written, reg_index,
                   reg_value, output ready);
endinterface

### hdl/small_risc_instruction_executor_top.sv
// Top level of the small RISC instruction executor: sequencer, memories, result queue.
//
//   channel   direction  handshake        word
//   req_bus   in         valid/ready      action, address, word_data
//   rsp_bus   out        valid/ready      next_pc, halted, illegal, reg_written,
//                                         reg_index, reg_value
//
// A step word passes through fetch, then decode with register file read, then
// execute, which overlaps the next word's fetch; ld and st hold off the next word
// in execute, since the single word memory port serves the data access after the fetch.
// Write, restart, ignored and stopped-step words go straight to the report state.
// Reset clears pc, the stop flags, the register valid bits and the queue; the
// word memory keeps no reset and is usable at once.
// Two result words can wait in the output queue; input stalls when it is full.
module small_risc_instruction_executor_top (
   input  logic           clock,
   input  logic           reset,
   srie_req_if.sink       req_bus,
   srie_rsp_if.source     rsp_bus
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REPORT = 5'b00010,
      ST_DECODE = 5'b00100,
      ST_EXEC   = 5'b01000,
      ST_LOAD   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [srie_pkg::PC_W-1:0]     pc_ff, pc_in, pc_cur;
   logic                          stop_ff, stop_in, stop_cur;
   logic                          bad_ff, bad_in, bad_cur;
   logic [srie_pkg::XLEN-1:0]     x_ins_ff, x_ins_in;
   logic                          va_ff, va_in, vb_ff, vb_in;
   logic                          ld_wb_ff, ld_wb_in;
   logic [srie_pkg::REG_W-1:0]    ld_idx_ff, ld_idx_in;
   logic [srie_pkg::NUM_REGS-1:0] rf_vld_ff, rf_vld_in;
   logic [1:0]                    cnt_ff, cnt_in;
   logic [1:0]                    q_cnt_ff, q_cnt_in;
   logic                          q_wr_ff, q_wr_in, q_rd_ff, q_rd_in;
   srie_pkg::result_type          q_ff [srie_pkg::Q_DEPTH];

   logic                          acc, pop, go_step, can_take;
   srie_pkg::exec_type            ex;

   logic                          mem_we, mem_re, ex_ld, ex_st;
   logic [srie_pkg::PC_W-1:0]     mem_waddr, mem_raddr;
   logic [srie_pkg::XLEN-1:0]     mem_wdata, mem_rdata;

   logic                          rf_re, rf_we;
   logic [srie_pkg::REG_W-1:0]    rfa_addr, rfb_addr, rf_waddr;
   logic [srie_pkg::XLEN-1:0]     rf_wdata, rfa_rdata, rfb_rdata, src1, src2;

   logic                          res_vld;
   srie_pkg::result_type          res;

   // ---------------------------------------------------------------- handshake
   assign acc = req_bus.valid && req_bus.ready;
   assign pop = rsp_bus.valid && rsp_bus.ready;

   // The execute cycle hands over to the next word unless it still needs the
   // memory port for a load or a store.
   always_comb begin
      unique case (state_ff) inside
         ST_IDLE, ST_REPORT, ST_LOAD: can_take = 1'b1;
         ST_EXEC:                     can_take = !ex.is_ld && !ex.is_st;
         default:                     can_take = 1'b0;
      endcase
   end

   // Credits cover words queued plus the one in flight.
   assign req_bus.ready = can_take && ((cnt_ff != 2'(srie_pkg::Q_DEPTH)) || pop);

   // ---------------------------------------------------------- core state view
   // State as it stands once the instruction in execute retires.
   assign pc_cur   = (state_ff == ST_EXEC) ? ex.npc : pc_ff;
   assign stop_cur = (state_ff == ST_EXEC) ? (stop_ff || ex.halt) : stop_ff;
   assign bad_cur  = (state_ff == ST_EXEC) ? (bad_ff || ex.bad) : bad_ff;

   assign go_step = (req_bus.action == srie_pkg::ACT_STEP) && !stop_cur;

   always_comb begin
      pc_in   = pc_cur;
      stop_in = stop_cur;
      bad_in  = bad_cur;
      if (acc && (req_bus.action == srie_pkg::ACT_RESTART)) begin
         pc_in   = '0;
         stop_in = 1'b0;
         bad_in  = 1'b0;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = ST_IDLE;
      unique case (state_ff) inside
         ST_IDLE, ST_REPORT, ST_LOAD: begin
            if (acc) begin
               state_in = go_step ? ST_DECODE : ST_REPORT;
            end
         end
         ST_DECODE: state_in = ST_EXEC;
         ST_EXEC: begin
            if (ex.is_ld) begin
               state_in = ST_LOAD;
            end else if (acc) begin
               state_in = go_step ? ST_DECODE : ST_REPORT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------- word memory
   // Data access of the instruction in execute; any other execute cycle leaves
   // the port to the word being accepted.
   assign ex_ld = (state_ff == ST_EXEC) && ex.is_ld;
   assign ex_st = (state_ff == ST_EXEC) && ex.is_st;

   // Read port: instruction fetch on accept, or the load in execute.
   assign mem_re    = (acc && go_step) || ex_ld;
   assign mem_raddr = ex_ld ? ex.maddr : pc_cur;

   // Write port: a write word on accept, or the store in execute.
   assign mem_we    = (acc && (req_bus.action == srie_pkg::ACT_WRITE)) || ex_st;
   assign mem_waddr = ex_st ? ex.maddr : srie_pkg::PC_W'(req_bus.address);
   assign mem_wdata = ex_st ? src2 : req_bus.word_data;

   srie_ram #(
      .WIDTH (srie_pkg::XLEN),
      .DEPTH (srie_pkg::MEM_WORDS)
   ) u_word_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ----------------------------------------------------------- register file
   // Two copies with identical writes give two read ports. Port B reads the
   // store data register for st, else the second source.
   assign rf_re    = (state_ff == ST_DECODE);
   assign rfa_addr = mem_rdata[20:16];
   assign rfb_addr = (mem_rdata[31:26] == srie_pkg::OP_ST) ? mem_rdata[25:21]
                                                           : mem_rdata[4:0];

   assign rf_we    = ((state_ff == ST_EXEC) && ex.wb && !ex.is_ld) ||
                     ((state_ff == ST_LOAD) && ld_wb_ff);
   assign rf_waddr = (state_ff == ST_EXEC) ? ex.widx : ld_idx_ff;
   assign rf_wdata = (state_ff == ST_EXEC) ? ex.wval : mem_rdata;

   srie_ram #(
      .WIDTH (srie_pkg::XLEN),
      .DEPTH (srie_pkg::NUM_REGS)
   ) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (rf_re),
      .rd_addr (rfa_addr),
      .rd_data (rfa_rdata)
   );

   srie_ram #(
      .WIDTH (srie_pkg::XLEN),
      .DEPTH (srie_pkg::NUM_REGS)
   ) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (rf_re),
      .rd_addr (rfb_addr),
      .rd_data (rfb_rdata)
   );

   // Never-written registers (and r0) read as zero through the valid bits.
   always_comb begin
      rf_vld_in = rf_vld_ff;
      if (rf_we) begin
         rf_vld_in[rf_waddr] = 1'b1;
      end
   end

   assign va_in = rf_re ? rf_vld_ff[rfa_addr] : va_ff;
   assign vb_in = rf_re ? rf_vld_ff[rfb_addr] : vb_ff;
   assign src1  = va_ff ? rfa_rdata : '0;
   assign src2  = vb_ff ? rfb_rdata : '0;

   // Hold the fetched word for the execute cycle.
   assign x_ins_in = (state_ff == ST_DECODE) ? mem_rdata : x_ins_ff;

   srie_exec u_exec (
      .ins  (x_ins_ff),
      .src1 (src1),
      .src2 (src2),
      .pc   (pc_ff),
      .ex   (ex)
   );

   assign ld_wb_in  = (state_ff == ST_EXEC) ? ex.wb   : ld_wb_ff;
   assign ld_idx_in = (state_ff == ST_EXEC) ? ex.widx : ld_idx_ff;

   // ------------------------------------------------------------ result words
   always_comb begin
      res_vld = 1'b0;
      res     = '0;
      unique case (state_ff)
         ST_REPORT: begin
            res_vld     = 1'b1;
            res.next_pc = srie_pkg::OUT_PC_W'(pc_ff);
            res.halted  = stop_ff;
            res.illegal = bad_ff;
         end
         ST_EXEC: begin
            res_vld         = !ex.is_ld;
            res.next_pc     = srie_pkg::OUT_PC_W'(pc_cur);
            res.halted      = stop_cur;
            res.illegal     = bad_cur;
            res.reg_written = ex.wb;
            res.reg_index   = ex.wb ? ex.widx : '0;
            res.reg_value   = ex.wb ? ex.wval : '0;
         end
         ST_LOAD: begin
            res_vld         = 1'b1;
            res.next_pc     = srie_pkg::OUT_PC_W'(pc_ff);
            res.halted      = stop_ff;
            res.illegal     = bad_ff;
            res.reg_written = ld_wb_ff;
            res.reg_index   = ld_wb_ff ? ld_idx_ff : '0;
            res.reg_value   = ld_wb_ff ? mem_rdata : '0;
         end
         default: begin
            res_vld = 1'b0;
         end
      endcase
   end

   // Two-entry output queue; advance pointers on push and pop.
   assign q_wr_in  = res_vld ? !q_wr_ff : q_wr_ff;
   assign q_rd_in  = pop ? !q_rd_ff : q_rd_ff;
   assign q_cnt_in = q_cnt_ff + 2'(res_vld) - 2'(pop);
   assign cnt_in   = cnt_ff + 2'(acc) - 2'(pop);

   assign rsp_bus.valid       = (q_cnt_ff != '0);
   assign rsp_bus.next_pc     = q_ff[q_rd_ff].next_pc;
   assign rsp_bus.halted      = q_ff[q_rd_ff].halted;
   assign rsp_bus.illegal     = q_ff[q_rd_ff].illegal;
   assign rsp_bus.reg_written = q_ff[q_rd_ff].reg_written;
   assign rsp_bus.reg_index   = q_ff[q_rd_ff].reg_index;
   assign rsp_bus.reg_value   = q_ff[q_rd_ff].reg_value;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pc_ff     <= '0;
         stop_ff   <= 1'b0;
         bad_ff    <= 1'b0;
         rf_vld_ff <= '0;
         cnt_ff    <= '0;
         q_cnt_ff  <= '0;
         q_wr_ff   <= 1'b0;
         q_rd_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         stop_ff   <= stop_in;
         bad_ff    <= bad_in;
         rf_vld_ff <= rf_vld_in;
         cnt_ff    <= cnt_in;
         q_cnt_ff  <= q_cnt_in;
         q_wr_ff   <= q_wr_in;
         q_rd_ff   <= q_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ins_ff  <= x_ins_in;
      va_ff     <= va_in;
      vb_ff     <= vb_in;
      ld_wb_ff  <= ld_wb_in;
      ld_idx_ff <= ld_idx_in;
      if (res_vld) begin
         q_ff[q_wr_ff] <= res;
      end
   end

   // --------------------------------------------------------------- assertions
   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("word memory read and write in the same cycle");

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (rf_waddr != srie_pkg::REG_ZERO))
      else $error("register zero written");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      res_vld |-> ((q_cnt_ff != 2'(srie_pkg::Q_DEPTH)) || pop))
      else $error("result queue overflow");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= 2'(srie_pkg::Q_DEPTH)) && (q_cnt_ff <= cnt_ff))
      else $error("credit count out of step with queue");

   a_no_step_when_stopped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE) |-> !stop_ff)
      else $error("instruction fetched while stopped");

   a_load_follows: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && ex.is_ld) |=> (state_ff == ST_LOAD))
      else $error("load did not enter its data cycle");

endmodule

### hdl/srie_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module srie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/srie_exec.sv
// Instruction decode and execute: ALU, compares, branch targets, load/store address.
module srie_exec (
   input  logic [srie_pkg::XLEN-1:0] ins,
   input  logic [srie_pkg::XLEN-1:0] src1,
   input  logic [srie_pkg::XLEN-1:0] src2,
   input  logic [srie_pkg::PC_W-1:0] pc,
   output srie_pkg::exec_type        ex
);

   srie_pkg::opcode_type        op;
   logic [srie_pkg::XLEN-1:0]   imm_ext;
   logic [srie_pkg::XLEN-1:0]   addr_sum;
   logic [2*srie_pkg::XLEN-1:0] product;
   logic                        wb_raw;

   assign op       = ins[31:26];
   assign imm_ext  = {{16{ins[15]}}, ins[15:0]};
   assign addr_sum = src1 + imm_ext;
   assign product  = src1 * src2;

   always_comb begin
      ex       = '0;
      wb_raw   = 1'b1;
      ex.npc   = pc + srie_pkg::PC_W'(1);
      ex.widx  = ins[25:21];
      ex.maddr = addr_sum[srie_pkg::PC_W-1:0];
      unique case (op)
         srie_pkg::OP_ADD:  ex.wval = src1 + src2;
         srie_pkg::OP_ADDI: ex.wval = src1 + imm_ext;
         srie_pkg::OP_SUB:  ex.wval = src1 - src2;
         srie_pkg::OP_SUBI: ex.wval = src1 - imm_ext;
         srie_pkg::OP_SGE:  ex.wval = {31'd0, $signed(src1) >= $signed(src2)};
         srie_pkg::OP_SGT:  ex.wval = {31'd0, $signed(src1) > $signed(src2)};
         srie_pkg::OP_SEQ:  ex.wval = {31'd0, src1 == src2};
         srie_pkg::OP_SEQI: ex.wval = {31'd0, src1 == imm_ext};
         srie_pkg::OP_MUL:  ex.wval = product[srie_pkg::XLEN-1:0];
         srie_pkg::OP_BT: begin
            wb_raw = 1'b0;
            if (src1 != '0) begin
               ex.npc = imm_ext[srie_pkg::PC_W-1:0];
            end
         end
         srie_pkg::OP_BF: begin
            wb_raw = 1'b0;
            if (src1 == '0) begin
               ex.npc = imm_ext[srie_pkg::PC_W-1:0];
            end
         end
         srie_pkg::OP_BA: begin
            wb_raw = 1'b0;
            ex.npc = imm_ext[srie_pkg::PC_W-1:0];
         end
         srie_pkg::OP_ST: begin
            wb_raw   = 1'b0;
            ex.is_st = 1'b1;
         end
         srie_pkg::OP_LD: ex.is_ld = 1'b1;
         srie_pkg::OP_CALL: begin
            // link is the old pc plus one, not wrapped
            ex.wval = srie_pkg::XLEN'(pc) + srie_pkg::XLEN'(1);
            ex.widx = srie_pkg::REG_LINK;
            ex.npc  = imm_ext[srie_pkg::PC_W-1:0];
         end
         srie_pkg::OP_JMP: begin
            wb_raw = 1'b0;
            ex.npc = src1[srie_pkg::PC_W-1:0];
         end
         srie_pkg::OP_HALT: begin
            wb_raw  = 1'b0;
            ex.halt = 1'b1;
            ex.npc  = pc;
         end
         default: begin
            // undefined opcode: stop, flag it, hold pc
            wb_raw  = 1'b0;
            ex.halt = 1'b1;
            ex.bad  = 1'b1;
            ex.npc  = pc;
         end
      endcase
      ex.wb = wb_raw && (ex.widx != srie_pkg::REG_ZERO);
   end

endmodule

### dv/tb_small_risc_instruction_executor_top.sv
// Self-checking testbench for the small RISC instruction executor top level.
`timescale 1ns / 100ps

module tb_small_risc_instruction_executor_top;
   import srie_pkg::*;

   typedef logic [XLEN-1:0] word_type;

   // Action 3 has no meaning; the block must report its state and change nothing.
   localparam action_type ACT_UNUSED   = 2'd3;
   localparam opcode_type OP_TOP       = '1;
   localparam int         RANDOM_WORDS = 1500;
   localparam int         CALM_FROM    = 700;
   localparam int         CALM_TO      = 950;
   localparam int         IDLE_PCT     = 29;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         SHOW_FAULTS  = 10;

   logic clock;
   logic reset;

   srie_req_if req_bus ();
   srie_rsp_if rsp_bus ();

   small_risc_instruction_executor_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // One row of the directed program: the word to send and, where it is obvious,
   // the status word that must come back.
   typedef struct {
      action_type          act;
      logic [ADDR_W-1:0]   addr;
      word_type            data;
      bit                  typed;
      result_type          want;
   } plan_row_type;

   plan_row_type plan [$];
   result_type   results_due [$];

   // Shadow copy of the core: registers, memory, pc and stop flags.
   word_type        gpr [NUM_REGS];
   word_type        ram [MEM_WORDS];
   bit              ram_set [MEM_WORDS];
   logic [PC_W-1:0] core_pc;
   bit              core_stopped;
   bit              core_bad;

   int         words_sent;
   int         fault_count = 0;
   int         cycle_count = 0;
   bit         calm;
   result_type seen_result;

   //---------------------------------------------------------------------------
   // Clock: 20 ns period.
   //---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   //---------------------------------------------------------------------------
   // Helpers
   //---------------------------------------------------------------------------
   function automatic word_type asm_word(opcode_type op, logic [REG_W-1:0] rd,
                                         logic [REG_W-1:0] rs, logic [15:0] imm);
      return {op, rd, rs, imm};
   endfunction

   function automatic result_type status_word(logic [OUT_PC_W-1:0] pc, logic halted,
                                              logic illegal);
      result_type r;
      r         = '0;
      r.next_pc = pc;
      r.halted  = halted;
      r.illegal = illegal;
      return r;
   endfunction

   // Apply one word to the shadow core and return the status word it produces.
   function automatic result_type execute_word(action_type act, logic [ADDR_W-1:0] addr,
                                               word_type data);
      result_type       r;
      word_type         ins, k, s1, s2, val, ea;
      opcode_type       op;
      logic [REG_W-1:0] rd, rs;
      logic [PC_W-1:0]  npc;
      bit               wb;
      r = '0;
      if (act == ACT_WRITE) begin
         ram[addr[PC_W-1:0]]     = data;
         ram_set[addr[PC_W-1:0]] = 1'b1;
      end else if (act == ACT_RESTART) begin
         core_pc      = '0;
         core_stopped = 1'b0;
         core_bad     = 1'b0;
      end else if (act == ACT_STEP && !core_stopped) begin
         ins = ram[core_pc];
         op  = ins[31:26];
         rd  = ins[25:21];
         rs  = ins[20:16];
         k   = {{16{ins[15]}}, ins[15:0]};
         s1  = gpr[rs];
         s2  = gpr[ins[REG_W-1:0]];
         ea  = s1 + k;
         npc = core_pc + 1'b1;
         val = '0;
         wb  = 1'b1;
         case (op)
            OP_ADD:  val = s1 + s2;
            OP_ADDI: val = s1 + k;
            OP_SUB:  val = s1 - s2;
            OP_SUBI: val = s1 - k;
            OP_SGE:  val = word_type'($signed(s1) >= $signed(s2));
            OP_SGT:  val = word_type'($signed(s1) > $signed(s2));
            OP_SEQ:  val = word_type'(s1 == s2);
            OP_BT: begin
               wb = 1'b0;
               if (s1 != '0) npc = k[PC_W-1:0];
            end
            OP_BF: begin
               wb = 1'b0;
               if (s1 == '0) npc = k[PC_W-1:0];
            end
            OP_BA: begin
               wb  = 1'b0;
               npc = k[PC_W-1:0];
            end
            OP_ST: begin
               wb                    = 1'b0;
               ram[ea[PC_W-1:0]]     = gpr[rd];
               ram_set[ea[PC_W-1:0]] = 1'b1;
            end
            OP_LD:   val = ram[ea[PC_W-1:0]];
            OP_CALL: begin
               // Link is the old pc plus one, without wrapping.
               val = word_type'(core_pc) + 1;
               rd  = REG_LINK;
               npc = k[PC_W-1:0];
            end
            OP_JMP: begin
               wb  = 1'b0;
               npc = s1[PC_W-1:0];
            end
            OP_MUL:  val = s1 * s2;
            OP_SEQI: val = word_type'(s1 == k);
            OP_HALT: begin
               wb           = 1'b0;
               core_stopped = 1'b1;
               npc          = core_pc;
            end
            default: begin
               wb           = 1'b0;
               core_stopped = 1'b1;
               core_bad     = 1'b1;
               npc          = core_pc;
            end
         endcase
         if (wb && rd != REG_ZERO) begin
            gpr[rd]       = val;
            r.reg_written = 1'b1;
            r.reg_index   = rd;
            r.reg_value   = val;
         end
         core_pc = npc;
      end
      r.next_pc = core_pc;
      r.halted  = core_stopped;
      r.illegal = core_bad;
      return r;
   endfunction

   // Random instruction: mostly legal, with a few registers so values interact.
   function automatic word_type make_instruction();
      opcode_type       op;
      logic [REG_W-1:0] rd, rs;
      logic [15:0]      imm;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 88)      op = opcode_type'($urandom_range(OP_ADD, OP_SEQI));
      else if (pick < 94) op = OP_HALT;
      else                op = opcode_type'($urandom_range(OP_HALT + 1, OP_TOP));
      rd = REG_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 7)
                                                : $urandom_range(0, 31));
      rs = REG_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 7)
                                                : $urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         imm = 16'($urandom_range(0, 31));
      end else if (pick < 50) begin
         case ($urandom_range(0, 4))
            0:       imm = 16'h0000;
            1:       imm = 16'h0001;
            2:       imm = 16'h7fff;
            3:       imm = 16'h8000;
            default: imm = 16'hffff;
         endcase
      end else begin
         imm = 16'($urandom_range(0, 16'hffff));
      end
      return asm_word(op, rd, rs, imm);
   endfunction

   task automatic plan_row(action_type act, logic [ADDR_W-1:0] addr, word_type data,
                           bit typed, result_type want);
      plan_row_type row;
      row.act   = act;
      row.addr  = addr;
      row.data  = data;
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endtask

   // Send one request word; call at a falling edge, returns at a falling edge.
   task automatic issue_word(action_type act, logic [ADDR_W-1:0] addr, word_type data,
                             bit typed, result_type want);
      result_type predicted;
      // Ignored words do not count toward the random budget.
      if (!(act == ACT_UNUSED || (act == ACT_STEP && core_stopped)))
         words_sent++;
      calm = (words_sent >= plan.size() + CALM_FROM) &&
             (words_sent <  plan.size() + CALM_TO);
      predicted = execute_word(act, addr, data);
      results_due.push_back(typed ? want : predicted);
      // Hold off the sender at random.
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.action    = act;
      req_bus.address   = addr;
      req_bus.word_data = data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic note_fault();
      fault_count++;
   endtask

   //---------------------------------------------------------------------------
   // Response side: stall at random, except during the calm stretch.
   //---------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   //---------------------------------------------------------------------------
   // Checker: compare every accepted result word with the oldest one due.
   //---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen_result.next_pc     = rsp_bus.next_pc;
         seen_result.halted      = rsp_bus.halted;
         seen_result.illegal     = rsp_bus.illegal;
         seen_result.reg_written = rsp_bus.reg_written;
         seen_result.reg_index   = rsp_bus.reg_index;
         seen_result.reg_value   = rsp_bus.reg_value;
         if (results_due.size() == 0) begin
            note_fault();
            if (fault_count <= SHOW_FAULTS)
               $display("%0t: result word with nothing due: pc %0d halted %b illegal %b",
                        $realtime, seen_result.next_pc, seen_result.halted,
                        seen_result.illegal);
         end else if (seen_result !== results_due[0]) begin
            note_fault();
            if (fault_count <= SHOW_FAULTS) begin
               $display("%0t: mismatch: expected pc %0d halt %b ill %b wr %b r%0d=%h",
                        $realtime, results_due[0].next_pc, results_due[0].halted,
                        results_due[0].illegal, results_due[0].reg_written,
                        results_due[0].reg_index, results_due[0].reg_value);
               $display("%0t: mismatch:      got pc %0d halt %b ill %b wr %b r%0d=%h",
                        $realtime, seen_result.next_pc, seen_result.halted,
                        seen_result.illegal, seen_result.reg_written,
                        seen_result.reg_index, seen_result.reg_value);
            end
            void'(results_due.pop_front());
         end else begin
            void'(results_due.pop_front());
         end
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_small_risc_instruction_executor_top: done, errors");
         $finish;
      end
   end

   //---------------------------------------------------------------------------
   // Stimulus
   //---------------------------------------------------------------------------
   initial begin : stimulus
      int                pick;
      word_type          ins, ea;
      logic [ADDR_W-1:0] spot;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.action    = ACT_WRITE;
      req_bus.address   = '0;
      req_bus.word_data = '0;
      calm              = 1'b0;
      words_sent        = 0;
      core_pc           = '0;
      core_stopped      = 1'b0;
      core_bad          = 1'b0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (ram[i]) begin
         ram[i]     = '0;
         ram_set[i] = 1'b0;
      end

      // Directed program. Load it first: every load word reports the reset state.
      plan_row(ACT_WRITE, 10'd0,  asm_word(OP_ADDI, 5'd1, REG_ZERO, 16'h7fff), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd1,  asm_word(OP_ADDI, 5'd2, REG_ZERO, 16'h8000), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd2,  asm_word(OP_SUB,  5'd3, 5'd2, 16'd1), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd3,  asm_word(OP_MUL,  5'd4, 5'd3, 16'd3), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd4,  asm_word(OP_SGE,  5'd5, 5'd2, 16'd1), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd5,  asm_word(OP_SGT,  5'd6, 5'd1, 16'd2), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd6,  asm_word(OP_SEQ,  5'd7, 5'd1, 16'd1), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd7,  asm_word(OP_SEQI, 5'd8, 5'd2, 16'h8000), 1,
               status_word(0, 0, 0));
      // Destination r0: must not be written.
      plan_row(ACT_WRITE, 10'd8,  asm_word(OP_ADD, REG_ZERO, 5'd1, 16'd1), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd9,  asm_word(OP_SUBI, 5'd9, REG_ZERO, 16'd1), 1,
               status_word(0, 0, 0));
      // Store and load through an effective address that wraps to the top word.
      plan_row(ACT_WRITE, 10'd10, asm_word(OP_ST, 5'd1, REG_ZERO, 16'hffff), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd11, asm_word(OP_LD, 5'd10, 5'd9, 16'd0), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd12, asm_word(OP_BT, REG_ZERO, REG_ZERO, 16'h0100), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd13, asm_word(OP_BF, REG_ZERO, REG_ZERO, 16'd20), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd20, asm_word(OP_BA, REG_ZERO, REG_ZERO, 16'd30), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd30, asm_word(OP_CALL, REG_ZERO, REG_ZERO, 16'd40), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd40, asm_word(OP_JMP, REG_ZERO, REG_LINK, 16'd0), 1,
               status_word(0, 0, 0));
      plan_row(ACT_WRITE, 10'd31, 32'hffff_ffff, 1, status_word(0, 0, 0));
      // Run it: straight line, then the branch chain, call and jump back to 31.
      repeat (17) plan_row(ACT_STEP, 10'd0, 32'd0, 0, '0);
      // Illegal opcode stops the core where it stands.
      plan_row(ACT_STEP,    10'd0, 32'd0, 1, status_word(31, 1, 1));
      plan_row(ACT_STEP,    10'd0, 32'd0, 1, status_word(31, 1, 1));
      plan_row(ACT_UNUSED,  10'h3ff, 32'hffff_ffff, 1, status_word(31, 1, 1));
      plan_row(ACT_RESTART, 10'd0, 32'd0, 1, status_word(0, 0, 0));
      plan_row(ACT_WRITE,   10'd0, asm_word(OP_HALT, REG_ZERO, REG_ZERO, 16'd0), 1,
               status_word(0, 0, 0));
      plan_row(ACT_STEP,    10'd0, 32'd0, 1, status_word(0, 1, 0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i])
         issue_word(plan[i].act, plan[i].addr, plan[i].data, plan[i].typed, plan[i].want);

      // Random part: mostly steps through programs that are built as the pc
      // reaches them, with loads, patches, restarts and noise mixed in.
      while (words_sent < plan.size() + RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         spot = ADDR_W'($urandom_range(0, MEM_WORDS - 1));
         if (core_stopped) begin
            if (pick < 50)
               issue_word(ACT_RESTART, spot, $urandom(), 0, '0);
            else if (pick < 75)
               issue_word(ACT_STEP, spot, $urandom(), 0, '0);
            else if (pick < 90)
               issue_word(ACT_WRITE, spot, make_instruction(), 0, '0);
            else
               issue_word(ACT_UNUSED, spot, $urandom(), 0, '0);
         end else if (pick < 62) begin
            // Never fetch or load a word that was never written: fill it first.
            if (!ram_set[core_pc])
               issue_word(ACT_WRITE, core_pc, make_instruction(), 0, '0);
            ins = ram[core_pc];
            if (ins[31:26] == OP_LD) begin
               ea = gpr[ins[20:16]] + {{16{ins[15]}}, ins[15:0]};
               if (!ram_set[ea[PC_W-1:0]])
                  issue_word(ACT_WRITE, ea[PC_W-1:0], $urandom(), 0, '0);
            end
            issue_word(ACT_STEP, spot, $urandom(), 0, '0);
         end else if (pick < 82) begin
            if ($urandom_range(0, 1) == 0)
               spot = core_pc + ADDR_W'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 75)
               issue_word(ACT_WRITE, spot, make_instruction(), 0, '0);
            else
               issue_word(ACT_WRITE, spot, $urandom(), 0, '0);
         end else if (pick < 88) begin
            issue_word(ACT_RESTART, spot, $urandom(), 0, '0);
         end else if (pick < 91) begin
            issue_word(ACT_UNUSED, spot, $urandom(), 0, '0);
         end else begin
            // Patch the program right ahead of the pc.
            issue_word(ACT_WRITE, core_pc + ADDR_W'($urandom_range(0, 3)),
                       make_instruction(), 0, '0);
         end
      end

      req_bus.valid = 1'b0;
      calm          = 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("tb_small_risc_instruction_executor_top: done, clean");
      else
         $display("tb_small_risc_instruction_executor_top: done, errors");
      $finish;
   end

endmodule
